// ===== src/vglos_pkg.sv =====
// Package for the voxel grid line-of-sight block.
// Holds the request codes, the config register indexes and the reset values.
// It has no dependencies.
package vglos_pkg;
    localparam logic [1:0] REQ_MARK    = 2'd0;
    localparam logic [1:0] REQ_QUERY   = 2'd1;
    localparam logic [1:0] REQ_LOS     = 2'd2;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    localparam logic [2:0] CFG_SIZE_X  = 3'd0;
    localparam logic [2:0] CFG_SIZE_Y  = 3'd1;
    localparam logic [2:0] CFG_SIZE_Z  = 3'd2;
    localparam logic [2:0] CFG_OBST    = 3'd3;
    localparam logic [2:0] CFG_FREE    = 3'd4;
    localparam logic [2:0] CFG_COLLIDE = 3'd5;

    localparam logic [4:0] SIZE_RST    = 5'd10;
    localparam logic [3:0] OBST_RST    = 4'd12;
    localparam logic [3:0] FREE_RST    = 4'd10;
    localparam logic [3:0] COLLIDE_RST = 4'd2;
    localparam logic [3:0] COST_RST    = 4'd1;
endpackage

// ===== src/vglos_ram.sv =====
// Generic single-port RAM with registered read.
// Parameters set word width and depth. No dependencies.
module vglos_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/voxel_grid_line_of_sight.sv =====
// Voxel grid line-of-sight block: top level with sequencer and cost RAM.
// Uses vglos_pkg and vglos_ram.
//
// Usage: requests arrive on i_req_* with valid/ready; one result word leaves
// on o_res_* with valid/ready. Config writes (index 0..5) go through i_cfg_*;
// the user must make them only while the block is idle; the block does not enforce it.
// After reset a clearing pass writes cost 1 into every RAM cell, all
// 2^(3*clog2(DIM_MAX)) cells (4096 at the default), during which no
// request is taken.
// Steps from accept to result valid: mark box writes the RAM once per covered
// cell; neighbor query runs select, wait and check for all six faces, or none
// if the cell is outside; line of sight runs the xy, xz and yz key compares,
// a step, a wait and a check per visited cell (up to 3*(DIM_MAX-1)), and no
// step on an index error or when both endpoints are the same cell.
// One request is processed at a time. The result sits in an output register;
// the next request is accepted while the receiver stalls, and its result
// waits until the register is emptied. After that the input stalls.
module voxel_grid_line_of_sight
    import vglos_pkg::*;
#(
    parameter int DIM_MAX = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  logic [1:0] i_req_type,
    input  logic [3:0] i_first_x,
    input  logic [3:0] i_first_y,
    input  logic [3:0] i_first_z,
    input  logic [3:0] i_second_x,
    input  logic [3:0] i_second_y,
    input  logic [3:0] i_second_z,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [1:0] o_answered_kind,
    output logic [5:0] o_free_neighbours,
    output logic       o_collision,
    output logic       o_index_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    localparam int DW = $clog2(DIM_MAX);
    localparam int CW = ((DW > 4) ? DW : 4) + 1;
    localparam int AW = 3 * DW;
    localparam int DEPTH = 1 << AW;
    localparam int KW = 2 * CW + 2;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MARK, ST_QSEL, ST_QWAIT, ST_QCHK,
        ST_LKEY, ST_LSTEP, ST_LWAIT, ST_LCHK, ST_DONE
    } t_state;

    t_state r_state;
    logic [4:0] r_size [3];
    logic [3:0] r_obst, r_free, r_coll;
    logic [3:0] r_a [3];
    logic [3:0] r_b [3];
    logic [CW-1:0] r_pos [3];
    logic [CW-1:0] r_den [3];
    logic [KW-1:0] r_num [3];
    logic [2:0] r_dir;
    logic [CW-1:0] r_lo [3];
    logic [CW-1:0] r_hi [3];
    logic [1:0] r_kind;
    logic [2:0] r_nb;
    logic [5:0] r_mask;
    logic r_hit, r_err, r_ok;
    logic [1:0] r_ax;
    logic [AW-1:0] r_clr;
    logic r_pend;
    logic [9:0] r_pend_res;
    logic r_less_xy, r_less_xz, r_less_yz;

    logic [CW-1:0] sz [3];
    logic we;
    logic [AW-1:0] addr;
    logic [3:0] wdata, rdata;

    vglos_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_size[i] == 5'd0) begin
                sz[i] = CW'(1);
            end else if (32'(r_size[i]) > DIM_MAX) begin
                sz[i] = CW'(DIM_MAX);
            end else begin
                sz[i] = CW'(r_size[i]);
            end
        end
    end

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return {x[DW-1:0], y[DW-1:0], z[DW-1:0]};
    endfunction

    // Shared compare: one pair of keys per cycle in the key phase.
    logic [2*KW-1:0] prod_l, prod_r;
    logic [1:0] ka, kb;
    logic kless;
    always_comb begin
        unique case (r_ax)
            2'd0: begin ka = 2'd0; kb = 2'd1; end
            2'd1: begin ka = 2'd0; kb = 2'd2; end
            default: begin ka = 2'd1; kb = 2'd2; end
        endcase
        prod_l = (2*KW)'(r_num[ka]) * (2*KW)'(r_den[kb]);
        prod_r = (2*KW)'(r_num[kb]) * (2*KW)'(r_den[ka]);
        if (r_den[ka] == '0) begin
            kless = 1'b0;
        end else if (r_den[kb] == '0) begin
            kless = 1'b1;
        end else begin
            kless = prod_l < prod_r;
        end
    end

    logic [1:0] step_ax;
    always_comb begin
        if (r_less_xy && r_less_xz) begin
            step_ax = 2'd0;
        end else if (r_less_yz) begin
            step_ax = 2'd1;
        end else begin
            step_ax = 2'd2;
        end
    end

    // Neighbor address for query step r_nb.
    logic [CW-1:0] np [3];
    logic nvalid;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            np[i] = CW'(r_a[i]);
        end
        nvalid = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_nb == 3'(2 * i)) begin
                np[i] = CW'(r_a[i]) + CW'(1);
                nvalid = (CW'(r_a[i]) + CW'(1)) < sz[i];
            end else if (r_nb == 3'(2 * i + 1)) begin
                np[i] = CW'(r_a[i]) - CW'(1);
                nvalid = r_a[i] != 4'd0;
            end
        end
    end

    logic in_a, in_b;
    assign in_a = (CW'(i_first_x) < sz[0]) && (CW'(i_first_y) < sz[1])
               && (CW'(i_first_z) < sz[2]);
    assign in_b = (CW'(i_second_x) < sz[0]) && (CW'(i_second_y) < sz[1])
               && (CW'(i_second_z) < sz[2]);

    always_comb begin
        we = 1'b0;
        wdata = r_obst;
        addr = cell_addr(r_pos[0], r_pos[1], r_pos[2]);
        unique case (r_state)
            ST_CLEAR: begin
                we = 1'b1;
                wdata = COST_RST;
                addr = r_clr;
            end
            ST_MARK: we = 1'b1;
            ST_QSEL, ST_QWAIT: addr = cell_addr(np[0], np[1], np[2]);
            default: ;
        endcase
    end

    assign o_req_ready = (r_state == ST_IDLE) && !r_pend;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_size[0] <= SIZE_RST;
            r_size[1] <= SIZE_RST;
            r_size[2] <= SIZE_RST;
            r_obst <= OBST_RST;
            r_free <= FREE_RST;
            r_coll <= COLLIDE_RST;
            o_res_valid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SIZE_X:  r_size[0] <= i_cfg_data;
                    CFG_SIZE_Y:  r_size[1] <= i_cfg_data;
                    CFG_SIZE_Z:  r_size[2] <= i_cfg_data;
                    CFG_OBST:    r_obst <= i_cfg_data[3:0];
                    CFG_FREE:    r_free <= i_cfg_data[3:0];
                    CFG_COLLIDE: r_coll <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (o_res_valid && i_res_ready) begin
                o_res_valid <= r_pend;
                {o_answered_kind, o_free_neighbours, o_collision, o_index_error} <= r_pend_res;
                if (r_pend) begin
                    r_pend <= 1'b0;
                end
            end else if (!o_res_valid && r_pend) begin
                o_res_valid <= 1'b1;
                {o_answered_kind, o_free_neighbours, o_collision, o_index_error} <= r_pend_res;
                r_pend <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_req_valid && o_req_ready && i_req_type != REQ_IGNORED) begin
                        r_kind <= i_req_type;
                        r_a[0] <= i_first_x;  r_a[1] <= i_first_y;  r_a[2] <= i_first_z;
                        r_b[0] <= i_second_x; r_b[1] <= i_second_y; r_b[2] <= i_second_z;
                        r_mask <= '0;
                        r_hit <= 1'b0;
                        r_err <= 1'b0;
                        r_nb <= '0;
                        r_ax <= '0;
                        unique case (i_req_type)
                            REQ_MARK: begin
                                r_lo[0] <= CW'(i_first_x);
                                r_lo[1] <= CW'(i_first_y);
                                r_lo[2] <= CW'(i_first_z);
                                r_hi[0] <= (CW'(i_second_x) > sz[0] - 1'b1) ? sz[0] - 1'b1
                                         : CW'(i_second_x);
                                r_hi[1] <= (CW'(i_second_y) > sz[1] - 1'b1) ? sz[1] - 1'b1
                                         : CW'(i_second_y);
                                r_hi[2] <= (CW'(i_second_z) > sz[2] - 1'b1) ? sz[2] - 1'b1
                                         : CW'(i_second_z);
                                r_pos[0] <= CW'(i_first_x);
                                r_pos[1] <= CW'(i_first_y);
                                r_pos[2] <= CW'(i_first_z);
                                r_ok <= 1'b0;
                                if (CW'(i_first_x) > ((CW'(i_second_x) > sz[0] - 1'b1)
                                        ? sz[0] - 1'b1 : CW'(i_second_x))
                                    || CW'(i_first_y) > ((CW'(i_second_y) > sz[1] - 1'b1)
                                        ? sz[1] - 1'b1 : CW'(i_second_y))
                                    || CW'(i_first_z) > ((CW'(i_second_z) > sz[2] - 1'b1)
                                        ? sz[2] - 1'b1 : CW'(i_second_z))) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_MARK;
                                end
                            end
                            REQ_QUERY: begin
                                if (!in_a) begin
                                    r_err <= 1'b1;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_QSEL;
                                end
                            end
                            default: begin
                                r_pos[0] <= CW'(i_first_x);
                                r_pos[1] <= CW'(i_first_y);
                                r_pos[2] <= CW'(i_first_z);
                                r_dir[0] <= i_second_x < i_first_x;
                                r_dir[1] <= i_second_y < i_first_y;
                                r_dir[2] <= i_second_z < i_first_z;
                                r_den[0] <= (i_second_x > i_first_x) ? CW'(i_second_x - i_first_x)
                                          : CW'(i_first_x - i_second_x);
                                r_den[1] <= (i_second_y > i_first_y) ? CW'(i_second_y - i_first_y)
                                          : CW'(i_first_y - i_second_y);
                                r_den[2] <= (i_second_z > i_first_z) ? CW'(i_second_z - i_first_z)
                                          : CW'(i_first_z - i_second_z);
                                r_num[0] <= KW'(1);
                                r_num[1] <= KW'(1);
                                r_num[2] <= KW'(1);
                                if (!(in_a && in_b)) begin
                                    r_err <= 1'b1;
                                    r_state <= ST_DONE;
                                end else if (i_first_x == i_second_x && i_first_y == i_second_y
                                             && i_first_z == i_second_z) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_LKEY;
                                end
                            end
                        endcase
                    end
                end
                ST_MARK: begin
                    if (r_pos[2] != r_hi[2]) begin
                        r_pos[2] <= r_pos[2] + 1'b1;
                    end else begin
                        r_pos[2] <= r_lo[2];
                        if (r_pos[1] != r_hi[1]) begin
                            r_pos[1] <= r_pos[1] + 1'b1;
                        end else begin
                            r_pos[1] <= r_lo[1];
                            if (r_pos[0] != r_hi[0]) begin
                                r_pos[0] <= r_pos[0] + 1'b1;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                end
                ST_QSEL: begin
                    r_ok <= nvalid;
                    r_state <= ST_QWAIT;
                end
                ST_QWAIT: r_state <= ST_QCHK;
                ST_QCHK: begin
                    if (r_ok && rdata < r_free) begin
                        r_mask[r_nb] <= 1'b1;
                    end
                    r_nb <= r_nb + 1'b1;
                    r_state <= (r_nb == 3'd5) ? ST_DONE : ST_QSEL;
                end
                ST_LKEY: begin
                    unique case (r_ax)
                        2'd0: r_less_xy <= kless;
                        2'd1: r_less_xz <= kless;
                        default: r_less_yz <= kless;
                    endcase
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
                    if (r_ax == 2'd2) begin
                        r_state <= ST_LSTEP;
                    end
                end
                ST_LSTEP: begin
                    r_num[step_ax] <= r_num[step_ax] + KW'(2);
                    r_pos[step_ax] <= r_dir[step_ax] ? r_pos[step_ax] - 1'b1
                                    : r_pos[step_ax] + 1'b1;
                    r_state <= ST_LWAIT;
                end
                ST_LWAIT: r_state <= ST_LCHK;
                ST_LCHK: begin
                    if (rdata > r_coll) begin
                        r_hit <= 1'b1;
                        r_state <= ST_DONE;
                    end else if (r_pos[0] == CW'(r_b[0]) && r_pos[1] == CW'(r_b[1])
                                 && r_pos[2] == CW'(r_b[2])) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_LKEY;
                    end
                end
                ST_DONE: begin
                    if (!r_pend) begin
                        r_pend <= 1'b1;
                        r_pend_res <= {r_kind, r_mask, r_hit, r_err};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_no_ready_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_req_ready)
        else $error("request taken during clearing pass");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> o_res_valid && $stable(o_answered_kind))
        else $error("result dropped under stall");
    a_mark_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_answered_kind == REQ_MARK) |-> !o_index_error && !o_collision)
        else $error("mark result flags set");
endmodule
